// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL. Every macro samples on the rising edge of
// clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every rising clock edge.
`define BLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define BLE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define BLE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ble_pkg.sv =====
package ble_pkg;

   localparam int CAPACITY    = 32;
   localparam int VALUE_BITS  = 16;
   localparam int MAX_OUT     = 32;
   localparam int INDEX_BITS  = 5;
   localparam int CMD_BITS    = 3;
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   // Wide enough for any entry position and for MAX_OUT itself.
   localparam int WIDE_BITS   = (CNT_BITS > 6) ? CNT_BITS : 6;

   localparam logic [CMD_BITS-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd4;

   typedef struct packed {
      logic [CMD_BITS-1:0]          command;
      logic signed [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] entry_value;
      logic [INDEX_BITS-1:0]        entry_index;
      logic                         last;
      logic                         list_empty;
      logic                         overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHL,
      OP_SHR,
      OP_ROT,
      OP_APPEND
   } cell_op_type;

   // Broadcast to every cell of the chain in each cycle.
   typedef struct packed {
      cell_op_type                  op;
      logic signed [VALUE_BITS-1:0] value;
      logic signed [VALUE_BITS-1:0] front;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== src/ble_cell.sv =====
// One list position. Holds, shifts toward the front, toward the back, takes part in a
// rotation of the occupied positions, or takes the command operand.
module ble_cell (
   input  logic                                   clock,
   input  ble_pkg::cell_ctl_type                  ctl,
   input  logic                                   tail_sel,
   input  logic                                   app_sel,
   input  logic signed [ble_pkg::VALUE_BITS-1:0]  left_value,
   input  logic signed [ble_pkg::VALUE_BITS-1:0]  right_value,
   output logic signed [ble_pkg::VALUE_BITS-1:0]  value_ff
);

   logic signed [ble_pkg::VALUE_BITS-1:0] value_in;

   always_comb begin
      unique case (ctl.op)
         ble_pkg::OP_HOLD:   value_in = value_ff;
         ble_pkg::OP_SHL:    value_in = right_value;
         ble_pkg::OP_SHR:    value_in = left_value;
         ble_pkg::OP_ROT:    value_in = tail_sel ? ctl.front : right_value;
         ble_pkg::OP_APPEND: value_in = app_sel ? ctl.value : value_ff;
         default:            value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/bounded_list_engine.sv =====
// Ordered list of up to CAPACITY signed values kept in a chain of cells, front
// in cell 0. One command is taken at a time; req_ready is high only while the
// block waits for a command. Push, pop, clear and unknown commands go straight
// from the work state to the output pass. Sorted insert and delete walk the
// list once by rotating the occupied cells through the front cell, one entry
// per cycle; an insert on a full list drops its operand. The list is then
// streamed out front to back by the same rotation, one result per cycle while
// rsp_ready stays high, or a single result flagged empty. A stall on the
// result side stops the rotation for as long as it lasts. A finished result
// waits in an output register, so the next command can be taken while the
// last result of the previous one is still pending.
module bounded_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ble_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ble_pkg::rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int CB = ble_pkg::CNT_BITS;
   localparam int WB = ble_pkg::WIDE_BITS;
   localparam int VB = ble_pkg::VALUE_BITS;

   ble_pkg::state_type             state_ff, state_in;
   logic [CB-1:0]                  count_ff, count_in;
   logic [CB-1:0]                  rem_ff, rem_in;
   logic [CB-1:0]                  k_ff, k_in;
   logic                           pend_ff, pend_in;
   logic                           ovf_ff, ovf_in;
   logic [ble_pkg::CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic signed [VB-1:0]           val_ff, val_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ble_pkg::rsp_type               rsp_ff, rsp_in;

   ble_pkg::cell_ctl_type          ctl;
   logic signed [VB-1:0]           cell_value [ble_pkg::CAPACITY];
   logic signed [VB-1:0]           front;
   logic                           rsp_free;
   logic                           emit_fire;
   logic                           emitting;
   logic                           is_add;
   logic                           full;
   logic [WB-1:0]                  wk;
   logic                           in_emit;
   logic                           insert_placed;
   logic                           empty_shown;
   logic                           empty_clean;

   // The chain of cells. Each cell learns from the count whether it is the
   // current tail (receives the front value during a rotation) or the first
   // free position (receives the operand on an append).
   for (genvar g = 0; g < ble_pkg::CAPACITY; g++) begin : g_cell
      logic signed [VB-1:0] left_v;
      logic signed [VB-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = ctl.value;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end

      if (g == ble_pkg::CAPACITY - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end

      ble_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .tail_sel    (count_ff == CB'(g + 1)),
         .app_sel     (count_ff == CB'(g)),
         .left_value  (left_v),
         .right_value (right_v),
         .value_ff    (cell_value[g])
      );
   end

   assign front     = cell_value[0];
   assign req_ready = (state_ff == ble_pkg::ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_add = (req_data.command == ble_pkg::CMD_PUSH) ||
                   (req_data.command == ble_pkg::CMD_INSERT);
   assign full   = (count_ff == CB'(ble_pkg::CAPACITY));

   // Position of the entry now at the front during the output pass; only the
   // first MAX_OUT positions produce results.
   assign wk       = WB'(k_ff);
   assign emitting = (wk < WB'(ble_pkg::MAX_OUT));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      pend_in   = pend_ff;
      ovf_in    = ovf_ff;
      cmd_in    = cmd_ff;
      val_in    = val_ff;
      rsp_in    = rsp_ff;
      emit_fire = 1'b0;
      ctl.op    = ble_pkg::OP_HOLD;
      ctl.value = val_ff;
      ctl.front = front;

      unique case (state_ff)
         ble_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               val_in   = req_data.value;
               rem_in   = count_ff;
               pend_in  = is_add && !full;
               ovf_in   = is_add && full;
               state_in = ble_pkg::ST_WORK;
            end
         end

         ble_pkg::ST_WORK: begin
            unique case (cmd_ff)
               ble_pkg::CMD_PUSH: begin
                  // When the list has room, every entry moves one place back and the
                  // operand enters at the front.
                  if (pend_ff) begin
                     ctl.op   = ble_pkg::OP_SHR;
                     count_in = count_ff + CB'(1);
                     pend_in  = 1'b0;
                  end
                  k_in     = '0;
                  state_in = ble_pkg::ST_EMIT;
               end

               ble_pkg::CMD_INSERT: begin
                  // Entries smaller than the operand rotate to the back; if the list has
                  // room, the operand is appended as soon as the front entry is greater than
                  // or equal to it, or when every old entry has passed.
                  if (pend_ff && ((rem_ff == '0) || (front >= val_ff))) begin
                     ctl.op   = ble_pkg::OP_APPEND;
                     count_in = count_ff + CB'(1);
                     pend_in  = 1'b0;
                  end else if (rem_ff != '0) begin
                     ctl.op = ble_pkg::OP_ROT;
                     rem_in = rem_ff - CB'(1);
                  end else begin
                     k_in     = '0;
                     state_in = ble_pkg::ST_EMIT;
                  end
               end

               ble_pkg::CMD_POP: begin
                  if (count_ff != '0) begin
                     ctl.op   = ble_pkg::OP_SHL;
                     count_in = count_ff - CB'(1);
                  end
                  k_in     = '0;
                  state_in = ble_pkg::ST_EMIT;
               end

               ble_pkg::CMD_DELETE: begin
                  // Each old entry passes the front once: a match leaves the
                  // chain, anything else rotates to the back.
                  if (rem_ff != '0) begin
                     if (front == val_ff) begin
                        ctl.op   = ble_pkg::OP_SHL;
                        count_in = count_ff - CB'(1);
                     end else begin
                        ctl.op = ble_pkg::OP_ROT;
                     end
                     rem_in = rem_ff - CB'(1);
                  end else begin
                     k_in     = '0;
                     state_in = ble_pkg::ST_EMIT;
                  end
               end

               ble_pkg::CMD_CLEAR: begin
                  count_in = '0;
                  k_in     = '0;
                  state_in = ble_pkg::ST_EMIT;
               end

               default: begin
                  // Unknown commands leave the list alone and only report it.
                  k_in     = '0;
                  state_in = ble_pkg::ST_EMIT;
               end
            endcase
         end

         ble_pkg::ST_EMIT: begin
            if (count_ff == '0) begin
               if (rsp_free) begin
                  emit_fire          = 1'b1;
                  rsp_in.entry_value = '0;
                  rsp_in.entry_index = '0;
                  rsp_in.last        = 1'b1;
                  rsp_in.list_empty  = 1'b1;
                  rsp_in.overflow    = ovf_ff;
                  state_in           = ble_pkg::ST_IDLE;
               end
            end else if (!emitting || rsp_free) begin
               // A full rotation of the occupied cells shows each entry at the
               // front once and leaves the list in its original order.
               ctl.op = ble_pkg::OP_ROT;
               if (emitting) begin
                  emit_fire          = 1'b1;
                  rsp_in.entry_value = front;
                  rsp_in.entry_index = wk[ble_pkg::INDEX_BITS-1:0];
                  rsp_in.last        = ((k_ff + CB'(1)) == count_ff) ||
                                       ((wk + WB'(1)) == WB'(ble_pkg::MAX_OUT));
                  rsp_in.list_empty  = 1'b0;
                  rsp_in.overflow    = ovf_ff;
               end
               k_in = k_ff + CB'(1);
               if ((k_ff + CB'(1)) == count_ff) begin
                  state_in = ble_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ble_pkg::ST_IDLE;
         end
      endcase

      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ble_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      pend_ff <= pend_in;
      ovf_ff  <= ovf_in;
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   assign in_emit       = (state_ff == ble_pkg::ST_EMIT);
   assign insert_placed = (state_ff == ble_pkg::ST_WORK) &&
                          (cmd_ff == ble_pkg::CMD_INSERT) && !pend_ff;
   assign empty_shown   = rsp_valid_ff && rsp_ff.list_empty;
   assign empty_clean   = (rsp_ff.entry_value == '0) && (rsp_ff.entry_index == '0) &&
                          rsp_ff.last;

   // The count never runs past the length of the chain.
   `BLE_ASSERT(a_count_bound, count_ff <= CB'(ble_pkg::CAPACITY), "entry count above capacity")

   // An empty-list transaction carries zero entry fields and closes the run.
   `BLE_ASSERT_IMP(a_empty_rsp, empty_shown, empty_clean, "empty result with entry data")

   // Once the operand is placed, an insert only rotates and the count holds.
   `BLE_ASSERT_NXT(a_insert_once, insert_placed, $stable(count_ff), "late count change")

   // The output pass always starts at the front entry.
   `BLE_ASSERT_IMP(a_emit_start, in_emit && !$past(in_emit), k_ff == '0, "pass start not at 0")

endmodule

// ===== bench/bounded_list_engine_tb.sv =====
module bounded_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ble_pkg::*;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // Command codes that the block does not decode; they leave the list alone
   // but still cause the whole list to be emitted.
   localparam logic [CMD_BITS-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int PHASE_ITEMS   = 40;
   localparam int DIRECTED_ROWS = 22;

   localparam rsp_type EMPTY_LISTING = '{entry_value: '0, entry_index: '0, last: 1'b1,
                                         list_empty: 1'b1, overflow: 1'b0};

   // One row of the directed table. When typed is set, the single result in
   // want is what the block must return; otherwise the predictor decides.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_row_type;

   step_row_type directed_steps [DIRECTED_ROWS] = '{
      // Pop, clear and delete on the list left by reset: one empty result each.
      '{'{CMD_POP,    16'sh0000}, 1'b1, EMPTY_LISTING},
      '{'{CMD_CLEAR,  16'sh0000}, 1'b1, EMPTY_LISTING},
      '{'{CMD_DELETE, 16'sd5},    1'b1, EMPTY_LISTING},
      '{'{CMD_PUSH,   16'sh7FFF}, 1'b1, '{16'sh7FFF, 5'd0, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_PUSH,   16'sh8000}, 1'b0, '0},
      // Sorted inserts, with equal values and both extremes.
      '{'{CMD_INSERT, 16'sh0000}, 1'b0, '0},
      '{'{CMD_INSERT, 16'sh0000}, 1'b0, '0},
      '{'{CMD_INSERT, 16'sh8000}, 1'b0, '0},
      '{'{CMD_INSERT, 16'sh7FFF}, 1'b0, '0},
      '{'{CMD_INSERT, 16'shFFFF}, 1'b0, '0},
      // Delete with two matches, then with none.
      '{'{CMD_DELETE, 16'sh0000}, 1'b0, '0},
      '{'{CMD_DELETE, 16'sd1234}, 1'b0, '0},
      '{'{CMD_SPARE_5, 16'sh0000}, 1'b0, '0},
      '{'{CMD_SPARE_6, 16'shFFFF}, 1'b0, '0},
      '{'{CMD_SPARE_7, 16'sh5555}, 1'b0, '0},
      '{'{CMD_POP,    16'shAAAA}, 1'b0, '0},
      '{'{CMD_PUSH,   16'sh5555}, 1'b0, '0},
      '{'{CMD_PUSH,   16'shAAAA}, 1'b0, '0},
      '{'{CMD_DELETE, 16'sh8000}, 1'b0, '0},
      '{'{CMD_CLEAR,  16'sh1234}, 1'b1, EMPTY_LISTING},
      '{'{CMD_INSERT, -16'sd7},   1'b1, '{-16'sd7, 5'd0, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_POP,    16'sh0000}, 1'b1, EMPTY_LISTING}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // The shadow copy of the list, front first, and the results still owed by
   // the block, oldest first.
   value_type shadow_list[$];
   rsp_type   listing_expect[$];

   int sender_idle_pct = 8;
   int rcvr_idle_pct   = 78;
   bit hold_start      = 1'b0;
   bit hold_taken      = 1'b0;
   int hold_left       = 0;

   int failures        = 0;
   int cycle_count     = 0;
   int cmds_sent       = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int overflow_drops  = 0;
   int deepest_list    = 0;

   bounded_list_engine dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one command to the shadow list. Returns 1 when a push or insert
   // had to be dropped because the list was already full.
   function automatic bit apply_command(input logic [CMD_BITS-1:0] code, input value_type v);
      int        slot;
      value_type kept[$];
      bit        dropped;
      dropped = 1'b0;
      case (code)
         CMD_PUSH: begin
            if (shadow_list.size() >= CAPACITY) dropped = 1'b1;
            else shadow_list.push_front(v);
         end
         CMD_INSERT: begin
            if (shadow_list.size() >= CAPACITY) begin
               dropped = 1'b1;
            end else begin
               // The new value goes ahead of any entries equal to it.
               slot = 0;
               while (slot < shadow_list.size() && shadow_list[slot] < v) slot++;
               shadow_list.insert(slot, v);
            end
         end
         CMD_POP: begin
            if (shadow_list.size() > 0) void'(shadow_list.pop_front());
         end
         CMD_DELETE: begin
            foreach (shadow_list[k]) begin
               if (shadow_list[k] != v) kept.push_back(shadow_list[k]);
            end
            shadow_list = kept;
         end
         CMD_CLEAR: shadow_list.delete();
         default: ;
      endcase
      return dropped;
   endfunction

   // Queues the listing that follows a command: every entry front to back,
   // capped at MAX_OUT results, or one result flagged empty.
   function automatic void expect_listing(input bit dropped);
      rsp_type r;
      int      n;
      if (shadow_list.size() == 0) begin
         r = EMPTY_LISTING;
         r.overflow = dropped;
         listing_expect.push_back(r);
      end else begin
         n = (shadow_list.size() > MAX_OUT) ? MAX_OUT : shadow_list.size();
         for (int i = 0; i < n; i++) begin
            r.entry_value = shadow_list[i];
            r.entry_index = INDEX_BITS'(i);
            r.last        = (i == n - 1);
            r.list_empty  = 1'b0;
            r.overflow    = dropped;
            listing_expect.push_back(r);
         end
      end
   endfunction

   // Operand mix: a small pool that makes duplicates likely, the extremes,
   // and the full range so that every bit of the value toggles.
   function automatic value_type pick_value();
      case ($urandom_range(3))
         0: return value_type'(int'($urandom_range(8)) - 4);
         1: begin
            case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offers one command transaction, with random idle cycles ahead of it, and
   // predicts its listing once the block accepts it. Valid and payload change
   // only at the falling edge; acceptance is judged at the rising edge.
   task automatic issue_command(input logic [CMD_BITS-1:0] code, input value_type v,
                                input bit typed = 1'b0, input rsp_type want = '0);
      bit dropped;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data.command <= code;
      req_data.value   <= v;
      do @(posedge clock); while (!req_ready);
      dropped = apply_command(code, v);
      if (typed) listing_expect.push_back(want);
      else expect_listing(dropped);
      cmds_sent++;
      // Unknown codes leave the list alone and do not count as items.
      if (code <= CMD_CLEAR) items_sent++;
      if (dropped) overflow_drops++;
      if (shadow_list.size() > deepest_list) deepest_list = shadow_list.size();
   endtask

   task automatic report_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v, inout bit bad);
      if (got_v !== want_v) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
         bad = 1'b1;
      end
   endtask

   // Receiver side. Normally ready is rolled against the idle percentage; once
   // the stimulus asks for back-pressure, ready stays low for a long stretch
   // so that the block's output fills and it stops accepting commands.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_start && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcvr_idle_pct);
      end
   end

   // Result checker: every result transaction is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (listing_expect.size() == 0) begin
            $display("%0t ns: result with none expected: value %0d index %0d last %0b",
                     $time, rsp_data.entry_value, rsp_data.entry_index, rsp_data.last);
            failures++;
         end else begin
            want = listing_expect.pop_front();
            bad  = 1'b0;
            report_field("entry_value", want.entry_value, rsp_data.entry_value, bad);
            report_field("entry_index", want.entry_index, rsp_data.entry_index, bad);
            report_field("last", want.last, rsp_data.last, bad);
            report_field("list_empty", want.list_empty, rsp_data.list_empty, bad);
            report_field("overflow", want.overflow, rsp_data.overflow, bad);
            if (bad) failures++;
            results_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int        burst;
      int        sel;
      int        reps;
      value_type v;

      // Reset is released at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: corner cases first, under the first idling mix.
      foreach (directed_steps[s]) begin
         issue_command(directed_steps[s].req.command, directed_steps[s].req.value,
                       directed_steps[s].typed, directed_steps[s].want);
      end

      // Random part in three phases: sender rarely idle with a slow receiver,
      // then the reverse, then both sides at full rate. The last phase opens
      // with a long receiver hold-off while commands keep coming.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 78 : 0;
         rcvr_idle_pct   = (phase == 0) ? 78 : (phase == 1) ? 8 : 0;
         if (phase == 2) hold_start = 1'b1;
         items_sent = 0;
         burst      = 0;
         while (items_sent < PHASE_ITEMS) begin
            sel = $urandom_range(9);
            if (burst == 0) begin
               // Fill the list to capacity, then try to overfill it.
               while (shadow_list.size() < CAPACITY) begin
                  issue_command(($urandom_range(1) != 0) ? CMD_INSERT : CMD_PUSH, pick_value());
               end
               reps = $urandom_range(1, 2);
               repeat (reps) begin
                  issue_command(($urandom_range(1) != 0) ? CMD_INSERT : CMD_PUSH, pick_value());
               end
            end else if (sel <= 3) begin
               reps = $urandom_range(3, 10);
               repeat (reps) begin
                  issue_command(($urandom_range(9) < 7) ? CMD_INSERT : CMD_PUSH, pick_value());
               end
            end else if (sel <= 5) begin
               // Deletes mostly aim at values that are in the list.
               reps = $urandom_range(1, 3);
               repeat (reps) begin
                  if (shadow_list.size() > 0 && $urandom_range(3) != 0)
                     v = shadow_list[$urandom_range(shadow_list.size() - 1)];
                  else
                     v = pick_value();
                  issue_command(CMD_DELETE, v);
               end
            end else if (sel <= 7) begin
               reps = $urandom_range(1, 4);
               repeat (reps) issue_command(CMD_POP, pick_value());
            end else if (sel == 8) begin
               issue_command(CMD_CLEAR, pick_value());
            end else begin
               case ($urandom_range(3))
                  0: issue_command(CMD_SPARE_5, pick_value());
                  1: issue_command(CMD_SPARE_6, pick_value());
                  2: issue_command(CMD_SPARE_7, pick_value());
                  default: issue_command(CMD_DELETE, value_type'($urandom));
               endcase
            end
            burst++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Let every owed result arrive, then watch a while for strays.
      while (listing_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d commands sent, %0d results checked, %0d dropped on a full list",
               cmds_sent, results_checked, overflow_drops);
      $display("tb: deepest list %0d entries; three idling mixes and one long output stall",
               deepest_list);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/ble_pkg.sv
src/ble_cell.sv
src/bounded_list_engine.sv
bench/bounded_list_engine_tb.sv
